// File: rtl/rtsp_pkg.sv
// shared types and constants for the rgb triplet subpixel spill unit
package rtsp_pkg;

    localparam int unsigned LevelW   = 8;
    localparam int unsigned BlurW    = 9;
    localparam int unsigned WeightW  = 10;
    localparam int unsigned WeightShift = 8;
    localparam logic [WeightW-1:0] MainTotal = 10'd768;
    localparam logic [BlurW-1:0]   BlurMax   = 9'd256;
    localparam logic [BlurW-1:0]   BlurReset = 9'd128;
    localparam logic [LevelW-1:0]  LevelMax  = 8'd255;

    // one source pixel
    typedef struct packed {
        logic [LevelW-1:0] red;
        logic [LevelW-1:0] green;
        logic [LevelW-1:0] blue;
        logic              end_of_line;
    } in_item_t;

    // one output subpixel pixel
    typedef struct packed {
        logic [LevelW-1:0] out_red;
        logic [LevelW-1:0] out_green;
        logic [LevelW-1:0] out_blue;
        logic              run_last;
    } out_item_t;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [LevelW-1:0] red_main;
        logic [LevelW-1:0] red_spill;
        logic [LevelW-1:0] green_main;
        logic [LevelW-1:0] green_spill;
        logic [LevelW-1:0] blue_main;
        logic [LevelW-1:0] blue_spill;
        logic [LevelW-1:0] prev_green_spill;
        logic [LevelW-1:0] prev_blue_main;
        logic [LevelW-1:0] prev_blue_spill;
        logic              line_start;
        logic              end_of_line;
    } work_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // position within one pixel's burst of results
    typedef enum logic [1:0] {
        STEP_PREV_TAIL,
        STEP_RED_MAIN,
        STEP_GREEN_MAIN,
        STEP_BLUE_TAIL
    } step_t;

endpackage

// File: rtl/rtsp_front.sv
// front end: pixel register, main/spill levels and line neighbour state
module rtsp_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [rtsp_pkg::BlurW-1:0] blur_weight,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rtsp_pkg::in_item_t    s_data,
    input  rtsp_pkg::queue_status_t q_status,
    output logic                  push,
    output rtsp_pkg::work_t       push_data
);
    import rtsp_pkg::*;

    // main and spill level of one channel, packed as {main, spill}
    function automatic logic [2*LevelW-1:0] spread_chan(
        input logic [BlurW-1:0]  w1,
        input logic [LevelW-1:0] x
    );
        logic [WeightW-1:0]          w2;
        logic [WeightW+LevelW-1:0]   main_prod;
        logic [BlurW+LevelW-1:0]     spill_prod;
        logic [WeightW-1:0]          main_lvl;
        logic [BlurW-1:0]            spill_lvl;
        logic [WeightW-1:0]          excess;
        logic [WeightW-1:0]          spill_sum;
        logic [LevelW-1:0]           main_out;
        logic [LevelW-1:0]           spill_out;
        w2         = MainTotal - {w1, 1'b0};
        main_prod  = w2 * {{WeightW{1'b0}}, x};
        spill_prod = w1 * {{BlurW{1'b0}}, x};
        main_lvl   = main_prod[WeightW+LevelW-1:WeightShift];
        spill_lvl  = spill_prod[BlurW+LevelW-1:WeightShift];
        excess     = main_lvl - {{(WeightW-LevelW){1'b0}}, LevelMax};
        spill_sum  = {1'b0, spill_lvl};
        main_out   = main_lvl[LevelW-1:0];
        if (main_lvl > {{(WeightW-LevelW){1'b0}}, LevelMax}) begin
            spill_sum = {1'b0, spill_lvl} + {1'b0, excess[WeightW-1:1]};
            main_out  = LevelMax;
        end
        if (spill_sum > {{(WeightW-LevelW){1'b0}}, LevelMax}) begin
            spill_out = LevelMax;
        end else begin
            spill_out = spill_sum[LevelW-1:0];
        end
        return {main_out, spill_out};
    endfunction

    in_item_t          pix_reg;
    logic              pix_valid_reg, pix_valid_next;
    logic [LevelW-1:0] held_green_spill_reg, held_green_spill_next;
    logic [LevelW-1:0] held_blue_main_reg, held_blue_main_next;
    logic [LevelW-1:0] held_blue_spill_reg, held_blue_spill_next;
    logic              inside_line_reg, inside_line_next;
    logic [2*LevelW-1:0] red_lv, green_lv, blue_lv;
    logic              s_take;

    // input transfer into the pixel register
    assign push    = pix_valid_reg && !q_status.full;
    assign s_ready = !pix_valid_reg || !q_status.full;
    assign s_take  = s_valid && s_ready;

    // level computation on the registered pixel
    assign red_lv   = spread_chan(blur_weight, pix_reg.red);
    assign green_lv = spread_chan(blur_weight, pix_reg.green);
    assign blue_lv  = spread_chan(blur_weight, pix_reg.blue);

    always_comb begin
        push_data.red_main         = red_lv[2*LevelW-1:LevelW];
        push_data.red_spill        = red_lv[LevelW-1:0];
        push_data.green_main       = green_lv[2*LevelW-1:LevelW];
        push_data.green_spill      = green_lv[LevelW-1:0];
        push_data.blue_main        = blue_lv[2*LevelW-1:LevelW];
        push_data.blue_spill       = blue_lv[LevelW-1:0];
        push_data.prev_green_spill = held_green_spill_reg;
        push_data.prev_blue_main   = held_blue_main_reg;
        push_data.prev_blue_spill  = held_blue_spill_reg;
        push_data.line_start       = !inside_line_reg;
        push_data.end_of_line      = pix_reg.end_of_line;
    end

    // neighbour state advances as each pixel enters the queue
    always_comb begin
        pix_valid_next        = pix_valid_reg;
        held_green_spill_next = held_green_spill_reg;
        held_blue_main_next   = held_blue_main_reg;
        held_blue_spill_next  = held_blue_spill_reg;
        inside_line_next      = inside_line_reg;
        if (push) begin
            pix_valid_next = 1'b0;
            if (pix_reg.end_of_line) begin
                held_green_spill_next = '0;
                held_blue_main_next   = '0;
                held_blue_spill_next  = '0;
                inside_line_next      = 1'b0;
            end else begin
                held_green_spill_next = push_data.green_spill;
                held_blue_main_next   = push_data.blue_main;
                held_blue_spill_next  = push_data.blue_spill;
                inside_line_next      = 1'b1;
            end
        end
        if (s_take) begin
            pix_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_valid_reg        <= 1'b0;
            held_green_spill_reg <= '0;
            held_blue_main_reg   <= '0;
            held_blue_spill_reg  <= '0;
            inside_line_reg      <= 1'b0;
        end else begin
            pix_valid_reg        <= pix_valid_next;
            held_green_spill_reg <= held_green_spill_next;
            held_blue_main_reg   <= held_blue_main_next;
            held_blue_spill_reg  <= held_blue_spill_next;
            inside_line_reg      <= inside_line_next;
        end
    end

    // pixel payload
    always_ff @(posedge aclk) begin
        if (s_take) begin
            pix_reg <= s_data;
        end
    end

endmodule

// File: rtl/rtsp_queue.sv
// two-entry queue between front and back
module rtsp_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  rtsp_pkg::work_t         push_data,
    input  logic                    pop,
    output rtsp_pkg::work_t         head,
    output rtsp_pkg::queue_status_t status
);
    import rtsp_pkg::*;

    work_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    // pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/rtsp_back.sv
// back end: steps each queued pixel through its results into the output register
module rtsp_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rtsp_pkg::work_t         head,
    input  rtsp_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output rtsp_pkg::out_item_t     m_data
);
    import rtsp_pkg::*;

    step_t     step_reg, step_next;
    step_t     step_now;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, result;
    logic      out_load, emit, is_final;

    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign out_load = !out_valid_reg || m_ready;
    assign emit     = out_load && !q_status.empty;
    assign pop      = emit && is_final;

    // result selection and step sequencing
    always_comb begin
        step_now = step_reg;
        if (step_reg == STEP_PREV_TAIL && head.line_start) begin
            step_now = STEP_RED_MAIN;
        end
        result   = '0;
        is_final = 1'b0;
        case (step_now)
            STEP_PREV_TAIL: begin
                result.out_red   = head.red_spill;
                result.out_green = head.prev_green_spill;
                result.out_blue  = head.prev_blue_main;
            end
            STEP_RED_MAIN: begin
                result.out_red   = head.red_main;
                result.out_green = head.green_spill;
                result.out_blue  = head.prev_blue_spill;
            end
            STEP_GREEN_MAIN: begin
                result.out_red   = head.red_spill;
                result.out_green = head.green_main;
                result.out_blue  = head.blue_spill;
                is_final         = !head.end_of_line;
            end
            STEP_BLUE_TAIL: begin
                result.out_red   = '0;
                result.out_green = head.green_spill;
                result.out_blue  = head.blue_main;
                is_final         = 1'b1;
            end
            default: begin
                result   = '0;
                is_final = 1'b1;
            end
        endcase
        result.run_last = is_final;

        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            if (is_final) begin
                step_next = STEP_PREV_TAIL;
            end else begin
                step_next = step_t'(step_now + 2'd1);
            end
        end else if (out_load) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_PREV_TAIL;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= result;
        end
    end

endmodule

// File: rtl/rgb_triplet_subpixel_spill_unit.sv
// top level of the rgb triplet subpixel spill unit
//
// Spreads each RGB source pixel over three output pixels in the manner of a
// CRT red/green/blue triplet mask, with neighbouring subpixels picking up a
// spill level set by the blur weight.
// Input channel s_valid/s_ready/s_data: one source pixel per transfer, with
// end_of_line on the last pixel of a line. Output channel m_valid/m_ready/
// m_data: one output pixel per transfer, run_last on the final result of a
// source pixel. A line's first pixel gives 2 results, middle pixels 3, the
// last pixel 4, and a one-pixel line 3.
// Configuration channel cfg_valid/cfg_ready/cfg_data writes the blur weight;
// cfg_ready is always high. Write it only while the block is idle.
// Path: the first result of a pixel passes the pixel register and a queue
// entry before it reaches the output register. The output sequencer emits
// one result per cycle while the receiver accepts them; the pixel
// register and a two-entry queue let the input keep flowing meanwhile.
// Reset (aresetn low, synchronous) empties the pipeline, sets the blur weight
// to 128 and starts a new line. A stalled receiver holds the output register;
// the queue then fills and s_ready drops.
module rgb_triplet_subpixel_spill_unit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  rtsp_pkg::in_item_t       s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output rtsp_pkg::out_item_t      m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [rtsp_pkg::BlurW-1:0] cfg_data
);
    import rtsp_pkg::*;

    logic [BlurW-1:0] blur_weight_reg, blur_weight_next;
    logic             fifo_push, fifo_pop;
    work_t            fifo_push_data, fifo_head;
    queue_status_t    fifo_status;

    // blur weight register, saturated at write
    assign cfg_ready = 1'b1;

    always_comb begin
        blur_weight_next = blur_weight_reg;
        if (cfg_valid && cfg_ready) begin
            blur_weight_next = (cfg_data > BlurMax) ? BlurMax : cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blur_weight_reg <= BlurReset;
        end else begin
            blur_weight_reg <= blur_weight_next;
        end
    end

    rtsp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .blur_weight (blur_weight_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_status    (fifo_status),
        .push        (fifo_push),
        .push_data   (fifo_push_data)
    );

    rtsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data (fifo_push_data),
        .pop       (fifo_pop),
        .head      (fifo_head),
        .status    (fifo_status)
    );

    rtsp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (fifo_head),
        .q_status (fifo_status),
        .pop      (fifo_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // front never writes a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> !fifo_status.full)
        else $error("push into full queue");

    // back never reads an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_pop |-> !fifo_status.empty)
        else $error("pop from empty queue");

    // a queue entry retires only with its final result
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_pop |=> (m_valid && m_data.run_last))
        else $error("entry retired without final result");

endmodule
